### sv/cor_pkg.sv
// ----------------------------------------------------------------------------
// cor_pkg: shared types, constants and point helpers of the circle rasterizer
// Widths, register indexes, the step record that travels front to back, and
// the functions that place one of the eight symmetric points on the canvas.
// ----------------------------------------------------------------------------
package cor_pkg;

   localparam int COORD_W         = 10;   // pixel row / column field
   localparam int COLOR_W         = 24;   // RGB colour field
   localparam int CFG_W           = 11;   // canvas size registers
   localparam int POS_W           = 12;   // signed step x / y
   localparam int ERR_W           = 15;   // signed decision error
   localparam int PIX_W           = 13;   // signed centre plus offset
   localparam int NUM_POINTS      = 8;
   localparam int PT_IDX_W        = $clog2(NUM_POINTS);
   localparam int FIELD_REACH     = 1024; // reach of the 10-bit outputs
   localparam int MAX_DIM_DEFAULT = 1024;
   localparam int QUEUE_DEPTH     = 4;
   localparam int CSR_IDX_W       = 1;

   localparam logic MODE_START   = 1'b0;
   localparam logic MODE_ADVANCE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_HEIGHT = 1'b1;

   // One Bresenham step, ready for the emitter.
   typedef struct packed {
      logic                     blank;   // advance with no circle: empty marker
      logic                     fin;     // circle ends with this step
      logic signed [POS_W-1:0]  x;
      logic signed [POS_W-1:0]  y;
      logic [COORD_W-1:0]       crow;
      logic [COORD_W-1:0]       ccol;
      logic [COLOR_W-1:0]       color;
   } step_rec_type;

   // Point order: (y,x) (-y,x) (y,-x) (-y,-x) (x,y) (-x,y) (x,-y) (-x,-y).
   // Bit 2 swaps the roles of x and y, bit 0 negates the row, bit 1 the column.
   function automatic logic signed [POS_W-1:0] row_offset(
      input logic signed [POS_W-1:0] x,
      input logic signed [POS_W-1:0] y,
      input logic [PT_IDX_W-1:0]     idx);
      logic signed [POS_W-1:0] base;
      base = idx[2] ? x : y;
      return idx[0] ? -base : base;
   endfunction

   function automatic logic signed [POS_W-1:0] col_offset(
      input logic signed [POS_W-1:0] x,
      input logic signed [POS_W-1:0] y,
      input logic [PT_IDX_W-1:0]     idx);
      logic signed [POS_W-1:0] base;
      base = idx[2] ? y : x;
      return idx[1] ? -base : base;
   endfunction

   function automatic logic signed [PIX_W-1:0] point_pos(
      input logic [COORD_W-1:0]      center,
      input logic signed [POS_W-1:0] off);
      return $signed({{(PIX_W-COORD_W){1'b0}}, center}) + PIX_W'(off);
   endfunction

   function automatic logic on_canvas(
      input logic signed [PIX_W-1:0] pos,
      input logic [CFG_W-1:0]        lim);
      return !pos[PIX_W-1] && (pos[PIX_W-2:0] < (PIX_W-1)'(lim));
   endfunction

endpackage

### sv/cor_req_if.sv
// ----------------------------------------------------------------------------
// cor_req_if: request channel of the circle rasterizer
// Valid/ready handshake carrying one start or advance request.
// ----------------------------------------------------------------------------
interface cor_req_if import cor_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               mode;
   logic [COORD_W-1:0] center_row;
   logic [COORD_W-1:0] center_col;
   logic [COORD_W-1:0] radius;
   logic [COLOR_W-1:0] color;

   modport source (output valid, mode, center_row, center_col, radius, color,
                   input ready);
   modport sink   (input valid, mode, center_row, center_col, radius, color,
                   output ready);
endinterface

### sv/cor_rsp_if.sv
// ----------------------------------------------------------------------------
// cor_rsp_if: response channel of the circle rasterizer
// Valid/ready handshake carrying one pixel write or one empty step marker.
// ----------------------------------------------------------------------------
interface cor_rsp_if import cor_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               pixel_valid;
   logic [COORD_W-1:0] pixel_row;
   logic [COORD_W-1:0] pixel_col;
   logic [COLOR_W-1:0] pixel_color;
   logic               step_last;
   logic               circle_finished;

   modport source (output valid, pixel_valid, pixel_row, pixel_col, pixel_color,
                   step_last, circle_finished, input ready);
   modport sink   (input valid, pixel_valid, pixel_row, pixel_col, pixel_color,
                   step_last, circle_finished, output ready);
endinterface

### sv/circle_outline_rasterizer_top.sv
// ----------------------------------------------------------------------------
// circle_outline_rasterizer_top: midpoint circle outline generator
// A start request latches centre, radius and colour; each advance request
// takes one Bresenham step. Every step yields its visible symmetric points.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  - requests; mode start begins a circle, mode advance steps it.
//   rsp_ch  - pixel writes in the fixed eight-point order, off-canvas points
//             dropped; step_last marks the final result of each request, and
//             a step with nothing visible gives one empty marker.
//   csr_*   - canvas width / height, to be written by the user only while the block is idle; not enforced.
// Throughput: the pixel emitter sends one point per cycle while rsp_ch.ready
//   allows, so each request yields 1 to 8 results.
//   The step unit takes a request every cycle while its queue has room.
// Path: the first result of a request reaches rsp_ch through the queue, the
//   emitter's step register and the output register.
// Reset: canvas size returns to 1024 x 1024, no circle is active, the queue
//   and output register are emptied.
// Stalls: while rsp_ch.ready is low the output register holds its result;
//   the queue (4 steps deep) keeps absorbing requests until it fills, then
//   req_ch.ready drops.
// ----------------------------------------------------------------------------
module circle_outline_rasterizer_top import cor_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   cor_req_if.sink              req_ch,
   cor_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   logic [CFG_W-1:0] canvas_width_ff, canvas_width_in;
   logic [CFG_W-1:0] canvas_height_ff, canvas_height_in;

   logic             q_push, q_pop, q_full, q_empty;
   step_rec_type     q_push_rec, q_head;

   // configuration registers: take a write whenever the enable is high
   always_comb begin
      canvas_width_in  = canvas_width_ff;
      canvas_height_in = canvas_height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CANVAS_WIDTH:  canvas_width_in  = csr_wdata;
            CSR_CANVAS_HEIGHT: canvas_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff  <= CFG_W'(FIELD_REACH);
         canvas_height_ff <= CFG_W'(FIELD_REACH);
      end else begin
         canvas_width_ff  <= canvas_width_in;
         canvas_height_ff <= canvas_height_in;
      end
   end

   // front: classify the request and advance the circle state
   cor_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .q_full   (q_full),
      .push     (q_push),
      .push_rec (q_push_rec)
   );

   // decouple step generation from pixel emission
   cor_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (q_push_rec),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   // back: clip against the canvas and drain one point per cycle while rsp_ch is ready
   cor_back #(
      .MAX_DIM (MAX_DIM)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .head          (q_head),
      .pop           (q_pop),
      .canvas_width  (canvas_width_ff),
      .canvas_height (canvas_height_ff),
      .rsp           (rsp_ch)
   );

endmodule

### sv/cor_front.sv
// ----------------------------------------------------------------------------
// cor_front: request intake and Bresenham step unit
// Takes one request per cycle while the queue has room, advances x, y and
// the decision error, and pushes the resulting step record into the queue.
// ----------------------------------------------------------------------------
module cor_front import cor_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   cor_req_if.sink      req,
   input  logic         q_full,
   output logic         push,
   output step_rec_type push_rec
);

   logic                    active_ff, active_in;
   logic signed [POS_W-1:0] x_ff, x_in;
   logic signed [POS_W-1:0] y_ff, y_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic [COORD_W-1:0]      crow_ff, crow_in;
   logic [COORD_W-1:0]      ccol_ff, ccol_in;
   logic [COLOR_W-1:0]      color_ff, color_in;
   logic                    fin;
   logic                    blank;

   assign req.ready = !q_full;
   assign push      = req.valid && !q_full;

   always_comb begin
      active_in = active_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      err_in    = err_ff;
      crow_in   = crow_ff;
      ccol_in   = ccol_ff;
      color_in  = color_ff;
      fin       = 1'b0;
      blank     = 1'b0;
      priority if (req.mode == MODE_START) begin
         x_in      = '0;
         y_in      = $signed(POS_W'(req.radius));
         err_in    = ERR_W'(3) - ERR_W'({req.radius, 1'b0});
         crow_in   = req.center_row;
         ccol_in   = req.center_col;
         color_in  = req.color;
         fin       = 1'b0;
         active_in = 1'b1;
      end else if (!active_ff) begin
         // no circle in progress: one empty marker, nothing moves
         blank = 1'b1;
         fin   = 1'b1;
      end else begin
         x_in = x_ff + POS_W'(1);
         if (err_ff > 0) begin
            y_in   = y_ff - POS_W'(1);
            err_in = err_ff + ((ERR_W'(x_in) - ERR_W'(y_in)) <<< 2) + ERR_W'(10);
         end else begin
            err_in = err_ff + (ERR_W'(x_in) <<< 2) + ERR_W'(6);
         end
         fin       = y_in < x_in;
         active_in = !fin;
      end
   end

   always_comb begin
      push_rec.blank = blank;
      push_rec.fin   = fin;
      push_rec.x     = x_in;
      push_rec.y     = y_in;
      push_rec.crow  = crow_in;
      push_rec.ccol  = ccol_in;
      push_rec.color = color_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (push) begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         err_ff   <= err_in;
         crow_ff  <= crow_in;
         ccol_ff  <= ccol_in;
         color_ff <= color_in;
      end
   end

endmodule

### sv/cor_queue.sv
// ----------------------------------------------------------------------------
// cor_queue: step record queue
// Small register FIFO between the step unit and the pixel emitter.
// ----------------------------------------------------------------------------
module cor_queue import cor_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  step_rec_type push_rec,
   input  logic         pop,
   output logic         full,
   output logic         empty,
   output step_rec_type head
);

   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   step_rec_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                              : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                              : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

endmodule

### sv/cor_back.sv
// ----------------------------------------------------------------------------
// cor_back: pixel emitter
// Loads a step record, masks off points outside the canvas, and sends the
// visible points one per cycle while rsp.ready allows (one empty marker when
// none is visible) through an output register.
module cor_back import cor_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  step_rec_type     head,
   output logic             pop,
   input  logic [CFG_W-1:0] canvas_width,
   input  logic [CFG_W-1:0] canvas_height,
   cor_rsp_if.source        rsp
);

   localparam int               CAP   = (MAX_DIM < FIELD_REACH) ? MAX_DIM : FIELD_REACH;
   localparam logic [CFG_W-1:0] CAP_L = CFG_W'(CAP);

   logic [CFG_W-1:0]          lim_h, lim_w;
   logic [NUM_POINTS-1:0]     head_mask;
   logic [NUM_POINTS-1:0]     rest;
   logic [PT_IDX_W-1:0]       sel;
   logic signed [PIX_W-1:0]   cur_row, cur_col;
   logic                      out_free, emit, done;

   logic                      active_ff, active_in;
   logic [NUM_POINTS-1:0]     mask_ff, mask_in;
   step_rec_type              cur_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      pix_valid_ff;
   logic [COORD_W-1:0]        row_ff, col_ff;
   logic [COLOR_W-1:0]        color_ff;
   logic                      last_ff, fin_ff;

   assign lim_h = (canvas_height > CAP_L) ? CAP_L : canvas_height;
   assign lim_w = (canvas_width  > CAP_L) ? CAP_L : canvas_width;

   // visibility of all eight points of the record about to load
   always_comb begin
      for (int i = 0; i < NUM_POINTS; i++) begin
         head_mask[i] = !head.blank
            && on_canvas(point_pos(head.crow,
                            row_offset(head.x, head.y, PT_IDX_W'(i))), lim_h)
            && on_canvas(point_pos(head.ccol,
                            col_offset(head.x, head.y, PT_IDX_W'(i))), lim_w);
      end
   end

   // lowest remaining visible point
   always_comb begin
      sel = '0;
      for (int i = NUM_POINTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = PT_IDX_W'(i);
         end
      end
   end

   assign rest    = mask_ff & (mask_ff - 1'b1);
   assign cur_row = point_pos(cur_ff.crow, row_offset(cur_ff.x, cur_ff.y, sel));
   assign cur_col = point_pos(cur_ff.ccol, col_offset(cur_ff.x, cur_ff.y, sel));

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign emit     = active_ff && out_free;
   assign done     = emit && (rest == '0);
   assign pop      = !q_empty && (!active_ff || done);

   always_comb begin
      active_in    = active_ff;
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         mask_in = rest;
      end
      if (done) begin
         active_in = 1'b0;
      end
      if (pop) begin
         active_in = 1'b1;
         mask_in   = head_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      if (pop) begin
         cur_ff <= head;
      end
      if (emit) begin
         fin_ff <= cur_ff.fin;
         if (mask_ff == '0) begin
            pix_valid_ff <= 1'b0;
            row_ff       <= '0;
            col_ff       <= '0;
            color_ff     <= '0;
            last_ff      <= 1'b1;
         end else begin
            pix_valid_ff <= 1'b1;
            row_ff       <= cur_row[COORD_W-1:0];
            col_ff       <= cur_col[COORD_W-1:0];
            color_ff     <= cur_ff.color;
            last_ff      <= (rest == '0);
         end
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.pixel_valid     = pix_valid_ff;
   assign rsp.pixel_row       = row_ff;
   assign rsp.pixel_col       = col_ff;
   assign rsp.pixel_color     = color_ff;
   assign rsp.step_last       = last_ff;
   assign rsp.circle_finished = fin_ff;

   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.pixel_valid) |-> rsp.step_last)
      else $error("empty marker not flagged as last of its step");

   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.pixel_valid) |->
         (rsp.pixel_row == '0 && rsp.pixel_col == '0 && rsp.pixel_color == '0))
      else $error("empty marker carries pixel data");

   a_on_canvas: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.pixel_valid) |->
         (CFG_W'(rsp.pixel_row) < lim_h && CFG_W'(rsp.pixel_col) < lim_w))
      else $error("pixel outside the canvas");

endmodule
